// ----- hw/rtl/dtam_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dtam_pkg;

	localparam int YEAR_W   = 12;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int ADD_W    = 16;

	// running hour holds start_hour plus up to 1093 carried hours
	localparam int HOUR_ACC_W = 11;
	localparam int SUM_W      = ADD_W + 1;
	localparam int PROD_W     = 2 * SUM_W;
	localparam int RECIP_SHIFT = 22;

	localparam logic [SUM_W-1:0]      MIN_PER_HOUR = 17'd60;
	localparam logic [HOUR_ACC_W-1:0] HOUR_PER_DAY = 11'd24;
	localparam logic [MONTH_W-1:0]    MONTH_JAN    = 4'd1;
	localparam logic [MONTH_W-1:0]    MONTH_DEC    = 4'd12;
	localparam logic [DAY_W-1:0]      DAY_FIRST    = 5'd1;
	localparam logic [DAY_W-1:0]      DAY_LAST_DEC = 5'd31;
	// floor(2^22 / 60); the quotient it gives is exact or one low
	localparam logic [SUM_W-1:0]      RECIP_60     = 17'd69905;

	localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 12'd1980;
	localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 12'd2099;

	localparam logic CFG_MIN_YEAR = 1'b0;
	localparam logic CFG_MAX_YEAR = 1'b1;

	localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};
	localparam logic [DAY_W-1:0] MONTH_LEN_LEAP [12] = '{
		5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef struct packed {
		logic [YEAR_W-1:0]   start_year;
		logic [MONTH_W-1:0]  start_month;
		logic [DAY_W-1:0]    start_day;
		logic [HOUR_W-1:0]   start_hour;
		logic [MINUTE_W-1:0] start_minute;
		logic [ADD_W-1:0]    add_minutes;
	} in_t;

	typedef struct packed {
		logic [YEAR_W-1:0]   end_year;
		logic [MONTH_W-1:0]  end_month;
		logic [DAY_W-1:0]    end_day;
		logic [HOUR_W-1:0]   end_hour;
		logic [MINUTE_W-1:0] end_minute;
		logic                bad_month;
	} out_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic fix;
		logic step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic more_days;
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_FIX,
		ST_DAYS
	} state_t;

	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic div100;
		logic div400;
		div100 = 1'b0;
		div400 = 1'b0;
		for (int k = 0; k <= 40; k++) begin
			if (y == YEAR_W'(k * 100))
				div100 = 1'b1;
		end
		for (int k = 0; k <= 10; k++) begin
			if (y == YEAR_W'(k * 400))
				div400 = 1'b1;
		end
		return ((y[1:0] == 2'b00) && !div100) || div400;
	endfunction

	// month must be 1..12
	function automatic logic [DAY_W-1:0] month_len(input logic leap,
			input logic [MONTH_W-1:0] month);
		logic [MONTH_W-1:0] idx;
		idx = month - MONTH_JAN;
		return leap ? MONTH_LEN_LEAP[idx] : MONTH_LEN[idx];
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dtam_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dtam_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire              out_ready,
	input  dtam_pkg::status_t status,
	output dtam_pkg::cmd_t   cmd
);
	import dtam_pkg::*;

	state_t state_q, state_nxt;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ST_FIX;
			end
			ST_FIX: begin
				cmd.fix   = 1'b1;
				state_nxt = ST_DAYS;
			end
			ST_DAYS: begin
				if (status.more_days) begin
					cmd.step = 1'b1;
				end else if (!out_valid_q || out_ready) begin
					// output register is free or transfers this cycle
					cmd.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

	a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result overwritten before transfer");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !in_ready)
		else $error("second item taken while one is in flight");

	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid)
		else $error("emitted result not presented");

	a_step_only_days: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (state_q == ST_DAYS) && !cmd.emit)
		else $error("day step outside day loop");

endmodule

`default_nettype wire

// ----- hw/rtl/dtam_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dtam_dp (
	input  wire                clk,
	input  wire                arst_n,
	input  dtam_pkg::in_t      in_data,
	input  wire                cfg_we,
	input  wire                cfg_idx,
	input  wire [11:0]         cfg_data,
	input  dtam_pkg::cmd_t     cmd,
	output dtam_pkg::status_t  status,
	output dtam_pkg::out_t     out_data
);
	import dtam_pkg::*;

	logic [YEAR_W-1:0]     min_year_q, max_year_q;
	logic [YEAR_W-1:0]     year_q;
	logic [MONTH_W-1:0]    month_q;
	logic [DAY_W-1:0]      day_q;
	logic [HOUR_ACC_W-1:0] hour_q;
	logic [MINUTE_W-1:0]   minute_q;
	logic [SUM_W-1:0]      sum_q;
	logic [PROD_W-1:0]     prod_q;
	logic                  bad_q;
	out_t                  out_q;

	logic                  no_carry;
	logic [HOUR_ACC_W-1:0] q0, q_fix;
	logic [SUM_W-1:0]      r0, r_fix, q0_x60;

	logic                  month_ok, leap;
	logic [DAY_W-1:0]      len;
	logic [YEAR_W:0]       year_wide;
	logic [YEAR_W-1:0]     year_nxt;
	logic [MONTH_W-1:0]    month_nxt;
	logic [DAY_W-1:0]      day_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_year_q <= MIN_YEAR_RST;
			max_year_q <= MAX_YEAR_RST;
		end else if (cfg_we) begin
			if (cfg_idx == CFG_MIN_YEAR)
				min_year_q <= cfg_data;
			else if (cfg_idx == CFG_MAX_YEAR)
				max_year_q <= cfg_data;
		end
	end

	assign no_carry = sum_q < MIN_PER_HOUR;

	// quotient estimate from the reciprocal product, then one correction
	assign q0     = prod_q[RECIP_SHIFT +: HOUR_ACC_W];
	assign q0_x60 = {q0, 6'b0} - {4'b0, q0, 2'b0};
	assign r0     = sum_q - q0_x60;
	always_comb begin
		if (r0 >= MIN_PER_HOUR) begin
			q_fix = q0 + HOUR_ACC_W'(1);
			r_fix = r0 - MIN_PER_HOUR;
		end else begin
			q_fix = q0;
			r_fix = r0;
		end
	end

	assign month_ok = (month_q >= MONTH_JAN) && (month_q <= MONTH_DEC);
	assign leap     = is_leap(year_q);
	assign len      = month_ok ? month_len(leap, month_q) : DAY_FIRST;

	always_comb begin
		year_wide = {1'b0, year_q};
		month_nxt = month_q;
		day_nxt   = day_q;
		priority if (month_q == MONTH_DEC && day_q == DAY_LAST_DEC) begin
			day_nxt   = DAY_FIRST;
			month_nxt = MONTH_JAN;
			year_wide = {1'b0, year_q} + (YEAR_W+1)'(1);
		end else if (day_q == len) begin
			day_nxt   = DAY_FIRST;
			month_nxt = month_q + MONTH_W'(1);
		end else begin
			day_nxt = day_q + DAY_W'(1);
		end
		if (year_wide > {1'b0, max_year_q})
			year_nxt = min_year_q;
		else
			year_nxt = year_wide[YEAR_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			year_q   <= in_data.start_year;
			month_q  <= in_data.start_month;
			day_q    <= in_data.start_day;
			hour_q   <= HOUR_ACC_W'(in_data.start_hour);
			sum_q    <= SUM_W'(in_data.start_minute) + SUM_W'(in_data.add_minutes);
			bad_q    <= 1'b0;
		end
		if (cmd.mul)
			prod_q <= PROD_W'(sum_q) * PROD_W'(RECIP_60);
		if (cmd.fix) begin
			if (no_carry) begin
				minute_q <= sum_q[MINUTE_W-1:0];
			end else begin
				minute_q <= r_fix[MINUTE_W-1:0];
				hour_q   <= hour_q + q_fix;
			end
		end
		if (cmd.step) begin
			hour_q <= hour_q - HOUR_PER_DAY;
			if (month_ok) begin
				year_q  <= year_nxt;
				month_q <= month_nxt;
				day_q   <= day_nxt;
			end else begin
				bad_q <= 1'b1;
			end
		end
		if (cmd.emit) begin
			out_q.end_year   <= year_q;
			out_q.end_month  <= month_q;
			out_q.end_day    <= day_q;
			out_q.end_hour   <= hour_q[HOUR_W-1:0];
			out_q.end_minute <= minute_q;
			out_q.bad_month  <= bad_q;
		end
	end

	assign status.more_days = !no_carry && (hour_q >= HOUR_PER_DAY);
	assign out_data         = out_q;

	a_step_needs_day: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !no_carry && (hour_q >= HOUR_PER_DAY))
		else $error("day advanced without a full day pending");

	a_hour_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && !no_carry) |-> (hour_q < HOUR_PER_DAY))
		else $error("hour not reduced below a day at emit");

	a_minute_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (SUM_W'(minute_q) < MIN_PER_HOUR))
		else $error("minute out of range at emit");

endmodule

`default_nettype wire

// ----- hw/rtl/date_time_add_minutes_core.sv -----
// Adds a minute count to a calendar date and time.
// Input channel in_valid/in_ready carries in_data (start date, time and
// add_minutes); output channel out_valid/out_ready carries out_data (end
// date, time and bad_month). One item is worked at a time.
// The day loop advances the date (for a month in 1..12) by one day per cycle,
// D days in all, where D = (start_hour + (start_minute + add_minutes) / 60) / 24
// when the minutes carry into hours, else 0 (D is at most 46). A new item can
// be taken in the cycle after the result enters the output register.
// The output register holds the result until transferred; a stalled
// receiver only delays the next result, which waits in the day loop state.
// Configuration: cfg_we writes cfg_data to min_year (index 0) or max_year
// (index 1); write only while idle.
// Reset (arst_n low) empties the block and sets min_year 1980, max_year 2099.
`timescale 1ns / 1ps
`default_nettype none

module date_time_add_minutes_core (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_ready,
	input  dtam_pkg::in_t   in_data,
	output logic            out_valid,
	input  wire             out_ready,
	output dtam_pkg::out_t  out_data,
	input  wire             cfg_we,
	input  wire             cfg_idx,
	input  wire [11:0]      cfg_data
);
	import dtam_pkg::*;

	cmd_t    cmd;
	status_t status;

	dtam_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	dtam_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_data)
	);

endmodule

`default_nettype wire
